>>> design/deadline_ordered_timer_queue_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the deadline ordered timer queue
// Concurrent property macros sampled on clk with rst_n as the disable.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define DOTQ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue assertion failed");

// next-cycle implication
`define DOTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue assertion failed");

`endif

>>> design/dotq_pkg.sv
// ---------------------------------------------------------------------------
// Timer queue package
// Types, codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package dotq_pkg;

    localparam int TIME_W    = 48;
    localparam int DELAY_W   = 40;
    localparam int TAG_W     = 32;
    localparam int HANDLE_W  = 4;
    localparam int HANDLES   = 16;
    localparam int S_DATA_W  = 176;
    localparam int M_DATA_W  = 88;

    typedef enum logic [1:0] {
        FUNC_SET_REL = 2'd0,
        FUNC_SET_ABS = 2'd1,
        FUNC_REMOVE  = 2'd2,
        FUNC_SERVICE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_GRANTED = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_WAIT    = 3'd4,
        KIND_EMPTY   = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHECK,
        S_INS_CMP,
        S_REM_CHECK,
        S_REM_CMP,
        S_SRV_CHECK,
        S_SRV_CMP,
        S_DRP_CHECK,
        S_DRP_CMP,
        S_EMIT_FIRED,
        S_EMIT_FINAL
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_ZERO,
        IDX_ONE,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_ZERO
    } rd_sel_t;

    typedef enum logic {
        WA_IDX,
        WA_IDX_M1
    } wa_sel_t;

    typedef enum logic {
        WD_NEW,
        WD_RDATA
    } wd_sel_t;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    typedef struct packed {
        logic    load_item;
        idx_op_t idx_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    found_clr;
        logic    found_set;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    use_set_free;
        logic    use_clr_item;
        logic    use_clr_rdata;
        logic    res_ld;
        kind_t   res_kind;
        logic    out_push;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  full;
        logic  hit;
        logic  idx_zero;
        logic  idx_at_count;
        logic  count_zero;
        logic  ins_le;
        logic  due;
        logic  match;
        logic  found;
        logic  out_free;
    } stat_t;

endpackage

>>> design/dotq_ctrl.sv
// ---------------------------------------------------------------------------
// Timer queue controller
// Sequences insert, remove and service walks over the slot memory.
// ---------------------------------------------------------------------------
module dotq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  dotq_pkg::stat_t stat,
    output dotq_pkg::cmd_t  cmd
);

    dotq_pkg::state_t state_reg;
    dotq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dotq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dotq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = dotq_pkg::S_DISPATCH;
                end
            end
            dotq_pkg::S_DISPATCH:
            begin
                unique case (stat.func) inside
                    dotq_pkg::FUNC_SET_REL, dotq_pkg::FUNC_SET_ABS:
                    begin
                        state_next = stat.full ? dotq_pkg::S_EMIT_FINAL
                                               : dotq_pkg::S_INS_CHECK;
                    end
                    dotq_pkg::FUNC_REMOVE:
                    begin
                        state_next = stat.hit ? dotq_pkg::S_REM_CHECK
                                              : dotq_pkg::S_EMIT_FINAL;
                    end
                    default:
                    begin
                        state_next = dotq_pkg::S_SRV_CHECK;
                    end
                endcase
            end
            dotq_pkg::S_INS_CHECK:
            begin
                state_next = stat.idx_zero ? dotq_pkg::S_EMIT_FINAL : dotq_pkg::S_INS_CMP;
            end
            dotq_pkg::S_INS_CMP:
            begin
                state_next = stat.ins_le ? dotq_pkg::S_EMIT_FINAL : dotq_pkg::S_INS_CHECK;
            end
            dotq_pkg::S_REM_CHECK:
            begin
                state_next = stat.idx_at_count ? dotq_pkg::S_EMIT_FINAL
                                               : dotq_pkg::S_REM_CMP;
            end
            dotq_pkg::S_REM_CMP:
            begin
                state_next = dotq_pkg::S_REM_CHECK;
            end
            dotq_pkg::S_SRV_CHECK:
            begin
                state_next = stat.count_zero ? dotq_pkg::S_EMIT_FINAL
                                             : dotq_pkg::S_SRV_CMP;
            end
            dotq_pkg::S_SRV_CMP:
            begin
                state_next = stat.due ? dotq_pkg::S_EMIT_FIRED : dotq_pkg::S_EMIT_FINAL;
            end
            dotq_pkg::S_EMIT_FIRED:
            begin
                if (stat.out_free)
                begin
                    state_next = dotq_pkg::S_DRP_CHECK;
                end
            end
            dotq_pkg::S_DRP_CHECK:
            begin
                state_next = stat.idx_at_count ? dotq_pkg::S_SRV_CHECK
                                               : dotq_pkg::S_DRP_CMP;
            end
            dotq_pkg::S_DRP_CMP:
            begin
                state_next = dotq_pkg::S_DRP_CHECK;
            end
            dotq_pkg::S_EMIT_FINAL:
            begin
                if (stat.out_free)
                begin
                    state_next = dotq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dotq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready          = 1'b0;
        cmd               = '0;
        cmd.idx_op        = dotq_pkg::IDX_HOLD;
        cmd.rd_sel        = dotq_pkg::RD_IDX;
        cmd.wa_sel        = dotq_pkg::WA_IDX;
        cmd.wd_sel        = dotq_pkg::WD_NEW;
        cmd.res_kind      = dotq_pkg::KIND_EMPTY;
        unique case (state_reg)
            dotq_pkg::S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            dotq_pkg::S_DISPATCH:
            begin
                unique case (stat.func) inside
                    dotq_pkg::FUNC_SET_REL, dotq_pkg::FUNC_SET_ABS:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_ld   = 1'b1;
                            cmd.res_kind = dotq_pkg::KIND_FULL;
                        end
                        else
                        begin
                            cmd.idx_op = dotq_pkg::IDX_COUNT;
                        end
                    end
                    dotq_pkg::FUNC_REMOVE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.idx_op    = dotq_pkg::IDX_ZERO;
                            cmd.found_clr = 1'b1;
                        end
                        else
                        begin
                            cmd.res_ld   = 1'b1;
                            cmd.res_kind = dotq_pkg::KIND_REMOVED;
                        end
                    end
                    default:
                    begin
                        cmd.idx_op = dotq_pkg::IDX_ZERO;
                    end
                endcase
            end
            dotq_pkg::S_INS_CHECK:
            begin
                if (stat.idx_zero)
                begin
                    cmd.wr_en        = 1'b1;
                    cmd.wa_sel       = dotq_pkg::WA_IDX;
                    cmd.wd_sel       = dotq_pkg::WD_NEW;
                    cmd.cnt_inc      = 1'b1;
                    cmd.use_set_free = 1'b1;
                    cmd.res_ld       = 1'b1;
                    cmd.res_kind     = dotq_pkg::KIND_GRANTED;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dotq_pkg::RD_IDX_M1;
                end
            end
            dotq_pkg::S_INS_CMP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = dotq_pkg::WA_IDX;
                if (stat.ins_le)
                begin
                    cmd.wd_sel       = dotq_pkg::WD_NEW;
                    cmd.cnt_inc      = 1'b1;
                    cmd.use_set_free = 1'b1;
                    cmd.res_ld       = 1'b1;
                    cmd.res_kind     = dotq_pkg::KIND_GRANTED;
                end
                else
                begin
                    cmd.wd_sel = dotq_pkg::WD_RDATA;
                    cmd.idx_op = dotq_pkg::IDX_DEC;
                end
            end
            dotq_pkg::S_REM_CHECK:
            begin
                if (stat.idx_at_count)
                begin
                    cmd.cnt_dec      = 1'b1;
                    cmd.use_clr_item = 1'b1;
                    cmd.res_ld       = 1'b1;
                    cmd.res_kind     = dotq_pkg::KIND_REMOVED;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dotq_pkg::RD_IDX;
                end
            end
            dotq_pkg::S_REM_CMP:
            begin
                cmd.wr_en     = stat.found;
                cmd.wa_sel    = dotq_pkg::WA_IDX_M1;
                cmd.wd_sel    = dotq_pkg::WD_RDATA;
                cmd.found_set = stat.match;
                cmd.idx_op    = dotq_pkg::IDX_INC;
            end
            dotq_pkg::S_SRV_CHECK:
            begin
                if (stat.count_zero)
                begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = dotq_pkg::KIND_EMPTY;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dotq_pkg::RD_ZERO;
                end
            end
            dotq_pkg::S_SRV_CMP:
            begin
                cmd.res_ld = 1'b1;
                if (stat.due)
                begin
                    cmd.res_kind      = dotq_pkg::KIND_FIRED;
                    cmd.use_clr_rdata = 1'b1;
                end
                else
                begin
                    cmd.res_kind = dotq_pkg::KIND_WAIT;
                end
            end
            dotq_pkg::S_EMIT_FIRED:
            begin
                cmd.out_push = stat.out_free;
                cmd.idx_op   = stat.out_free ? dotq_pkg::IDX_ONE : dotq_pkg::IDX_HOLD;
            end
            dotq_pkg::S_DRP_CHECK:
            begin
                if (stat.idx_at_count)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dotq_pkg::RD_IDX;
                end
            end
            dotq_pkg::S_DRP_CMP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = dotq_pkg::WA_IDX_M1;
                cmd.wd_sel = dotq_pkg::WD_RDATA;
                cmd.idx_op = dotq_pkg::IDX_INC;
            end
            dotq_pkg::S_EMIT_FINAL:
            begin
                cmd.out_push = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/dotq_dpath.sv
// ---------------------------------------------------------------------------
// Timer queue datapath
// Sorted slot memory, walk index, handle map and result register.
// ---------------------------------------------------------------------------
module dotq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dotq_pkg::cmd_t                cmd,
    output dotq_pkg::stat_t               stat,
    input  logic [dotq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [dotq_pkg::M_DATA_W-1:0] m_tdata,
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int TW = dotq_pkg::TIME_W;
    localparam int HW = dotq_pkg::HANDLE_W;
    localparam int NH = dotq_pkg::HANDLES;

    dotq_pkg::slot_t slot_mem_reg [DEPTH];
    dotq_pkg::slot_t rdata_reg;

    dotq_pkg::func_t        func_reg;
    logic [TW-1:0]          now_reg;
    logic [TW-1:0]          deadline_reg;
    logic [dotq_pkg::TAG_W-1:0] tag_reg;
    logic [HW-1:0]          hsel_reg;
    logic [HW-1:0]          free_reg;

    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          idx_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [NH-1:0]          in_use_reg;
    logic [NH-1:0]          in_use_next;
    logic                   found_reg;

    dotq_pkg::kind_t        res_kind_reg;
    logic [HW-1:0]          res_handle_reg;
    logic [dotq_pkg::TAG_W-1:0] res_tag_reg;
    logic [TW-1:0]          res_wait_reg;

    logic                   m_tvalid_reg;
    logic [dotq_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [2:0]             m_tuser_reg;
    logic                   m_tlast_reg;

    logic [CW-1:0]          idx_m1;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    dotq_pkg::slot_t        wr_data;
    logic [HW-1:0]          free_handle;
    logic [TW:0]            rel_sum;
    logic [TW-1:0]          in_deadline;
    logic                   out_free;

    assign idx_m1 = idx_reg - CW'(1);
    assign out_free = !m_tvalid_reg || m_tready;

    // lowest free handle
    always_comb
    begin
        free_handle = '0;
        for (int i = NH - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_handle = HW'(i);
            end
        end
    end

    // set relative saturates at the top of the time range
    assign rel_sum = {1'b0, s_tdata[TW-1:0]} + (TW + 1)'(s_tdata[TW+dotq_pkg::DELAY_W-1:TW]);

    always_comb
    begin
        if (dotq_pkg::func_t'(s_tuser) == dotq_pkg::FUNC_SET_REL)
        begin
            in_deadline = rel_sum[TW] ? {TW{1'b1}} : rel_sum[TW-1:0];
        end
        else
        begin
            in_deadline = s_tdata[2*TW+dotq_pkg::DELAY_W-1:TW+dotq_pkg::DELAY_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg     <= dotq_pkg::func_t'(s_tuser);
            now_reg      <= s_tdata[TW-1:0];
            deadline_reg <= in_deadline;
            tag_reg      <= s_tdata[2*TW+dotq_pkg::DELAY_W+dotq_pkg::TAG_W-1:
                                    2*TW+dotq_pkg::DELAY_W];
            hsel_reg     <= s_tdata[2*TW+dotq_pkg::DELAY_W+dotq_pkg::TAG_W+HW-1:
                                    2*TW+dotq_pkg::DELAY_W+dotq_pkg::TAG_W];
            free_reg     <= free_handle;
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            dotq_pkg::RD_IDX:    rd_addr = idx_reg[AW-1:0];
            dotq_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            default:             rd_addr = '0;
        endcase
        unique case (cmd.wa_sel)
            dotq_pkg::WA_IDX_M1: wr_addr = idx_m1[AW-1:0];
            default:             wr_addr = idx_reg[AW-1:0];
        endcase
        unique case (cmd.wd_sel)
            dotq_pkg::WD_RDATA:
            begin
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_data.deadline = deadline_reg;
                wr_data.tag      = tag_reg;
                wr_data.handle   = free_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            slot_mem_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= slot_mem_reg[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            dotq_pkg::IDX_COUNT: idx_next = count_reg;
            dotq_pkg::IDX_ZERO:  idx_next = '0;
            dotq_pkg::IDX_ONE:   idx_next = CW'(1);
            dotq_pkg::IDX_INC:   idx_next = idx_reg + CW'(1);
            dotq_pkg::IDX_DEC:   idx_next = idx_m1;
            default:             idx_next = idx_reg;
        endcase

        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        in_use_next = in_use_reg;
        if (cmd.use_set_free)
        begin
            in_use_next = in_use_next | (NH'(1) << free_reg);
        end
        if (cmd.use_clr_item)
        begin
            in_use_next = in_use_next & ~(NH'(1) << hsel_reg);
        end
        if (cmd.use_clr_rdata)
        begin
            in_use_next = in_use_next & ~(NH'(1) << rdata_reg.handle);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            count_reg  <= '0;
            in_use_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            in_use_reg <= in_use_next;
            if (cmd.found_clr)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.found_set)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_ld)
        begin
            res_kind_reg <= cmd.res_kind;
            case (cmd.res_kind)
                dotq_pkg::KIND_GRANTED:
                begin
                    res_handle_reg <= free_reg;
                    res_tag_reg    <= '0;
                    res_wait_reg   <= '0;
                end
                dotq_pkg::KIND_REMOVED:
                begin
                    res_handle_reg <= hsel_reg;
                    res_tag_reg    <= '0;
                    res_wait_reg   <= '0;
                end
                dotq_pkg::KIND_FIRED:
                begin
                    res_handle_reg <= rdata_reg.handle;
                    res_tag_reg    <= rdata_reg.tag;
                    res_wait_reg   <= '0;
                end
                dotq_pkg::KIND_WAIT:
                begin
                    res_handle_reg <= '0;
                    res_tag_reg    <= '0;
                    res_wait_reg   <= rdata_reg.deadline - now_reg;
                end
                default:
                begin
                    res_handle_reg <= '0;
                    res_tag_reg    <= '0;
                    res_wait_reg   <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_push)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_push)
        begin
            m_tdata_reg <= {4'b0, res_wait_reg, res_tag_reg, res_handle_reg};
            m_tuser_reg <= res_kind_reg;
            m_tlast_reg <= (res_kind_reg != dotq_pkg::KIND_FIRED);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        stat.func         = func_reg;
        stat.full         = (count_reg >= CW'(DEPTH)) || (&in_use_reg);
        stat.hit          = in_use_reg[hsel_reg];
        stat.idx_zero     = (idx_reg == '0);
        stat.idx_at_count = (idx_reg == count_reg);
        stat.count_zero   = (count_reg == '0);
        stat.ins_le       = (rdata_reg.deadline <= deadline_reg);
        stat.due          = (rdata_reg.deadline < now_reg);
        stat.match        = (rdata_reg.handle == hsel_reg);
        stat.found        = found_reg;
        stat.out_free     = out_free;
    end

endmodule

>>> design/deadline_ordered_timer_queue_unit.sv
// ---------------------------------------------------------------------------
// Deadline ordered timer queue
// Up to DEPTH timers (at most sixteen handles) held in a single-port slot
// memory sorted by deadline, ties in insertion order. One item at a time;
// a result waits in the output register while the next item is taken.
// Each item walks the slot memory in read/compare/write steps. A set shifts
// every timer later than the new one up one slot; a full queue is answered
// without a walk. A remove walks all pending timers, closing the gap behind
// the match; a handle not pending is answered without a walk. A service reads
// the head; each expired timer is emitted and the rest shifted down before the
// head is read again, ending with a wait or empty result. Each result then
// waits for the output to be free.
// No clearing pass after reset.
// ---------------------------------------------------------------------------
module deadline_ordered_timer_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_now[47:0], delay_us[87:48], abs_deadline[135:88], tag[167:136],
    // handle[171:168], zero fill to 176
    input  logic [175:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // handle_out[3:0], tag_out[35:4], wait_us[83:36], zero fill to 88
    output logic [87:0]  m_tdata,
    // kind[2:0]
    output logic [2:0]   m_tuser,
    // last
    output logic         m_tlast
);

    dotq_pkg::cmd_t  cmd;
    dotq_pkg::stat_t stat;

    dotq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dotq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> design/dotq_checker.sv
// ---------------------------------------------------------------------------
// Timer queue port checker
// Port-level properties of the timer queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "deadline_ordered_timer_queue_unit_assert.svh"

module dotq_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [87:0]  m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    logic out_stall;
    logic status_kind;

    assign out_stall   = m_tvalid && !m_tready;
    assign status_kind = (m_tuser == 3'(dotq_pkg::KIND_FULL))
                      || (m_tuser == 3'(dotq_pkg::KIND_WAIT))
                      || (m_tuser == 3'(dotq_pkg::KIND_EMPTY));

    // stalled result holds
    `DOTQ_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable({m_tuser, m_tlast, m_tdata}))

    // only a fired timer leaves the item open
    `DOTQ_ASSERT_IMPLY(a_last_kind, m_tvalid, m_tlast == (m_tuser != 3'(dotq_pkg::KIND_FIRED)))

    // one item in work at a time
    `DOTQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // status results carry no handle
    `DOTQ_ASSERT_IMPLY(a_status_no_handle, m_tvalid && status_kind, m_tdata[3:0] == 4'd0)

endmodule

bind deadline_ordered_timer_queue_unit dotq_checker u_dotq_checker (.*);
